### sv/mccd_pkg.sv
package mccd_pkg;

	// Field widths of the stream words.
	localparam int CMD_W       = 2;
	localparam int VAL_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 12;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLVE  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_SOLVED      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 2'd3;

	// Largest reportable coin count; larger minimums saturate here.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

	// Verdict of the relax unit on the coin and table entry it is shown.
	typedef struct packed {
		logic usable;   // coin is nonzero and not larger than the current sum
		logic improve;  // table entry is reachable and one more beats the best so far
	} relax_flags_t;

endpackage

### sv/mccd_ram.sv
module mccd_ram import mccd_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/mccd_relax_unit.sv
module mccd_relax_unit import mccd_pkg::*; #(
	parameter int SW = 12,
	parameter int CW = 13
) (
	input  logic [VAL_W-1:0] coin,
	input  logic [SW-1:0]    sum,
	input  logic [CW-1:0]    prev,
	input  logic [CW-1:0]    best,
	output logic [SW-1:0]    addr,
	output logic [CW-1:0]    cand,
	output relax_flags_t     flags
);

	logic [VAL_W-1:0] sum_x;
	logic [VAL_W-1:0] diff;

	// One subtract for the table address, one compare for usability,
	// one increment and compare for the running minimum.
	assign sum_x = VAL_W'(sum);
	assign diff  = sum_x - coin;
	assign addr  = diff[SW-1:0];
	assign cand  = prev + CW'(1);

	assign flags.usable  = (coin != '0) && (coin <= sum_x);
	assign flags.improve = (prev != '1) && (cand < best);

endmodule

### sv/min_coin_change_dp_unit.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: command, coin_value, target_sum
// m_*      out  m_tvalid/m_tready  m_tdata: status, coin_count
//
// For every sum from 1 to target_sum, a solve visits every stored coin through
// one coin read, one cost-table read and one compare in the shared relax unit;
// the cost table has a single read port.
// Reset (arst_n low) empties the coin list and the output register; the memories
// keep no reset and every table entry a solve reads was written by that solve.
// A result waits in the output register while m_tready is low; the block still
// accepts words when idle and stalls while a solve runs or a second result waits.
module min_coin_change_dp_unit import mccd_pkg::*; #(
	parameter int MAX_COINS = 16,
	parameter int MAX_SUM   = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [1:0] command, [17:2] coin_value, [33:18] target_sum, [39:34] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] status, [13:2] coin_count, [15:14] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// Sum index width, and a cost entry one bit wider so that all ones can
	// mark an unreachable sum above any real count.
	localparam int SW   = $clog2(MAX_SUM);
	localparam int CW   = SW + 1;
	localparam int CNTW = $clog2(MAX_COINS + 1);
	localparam int CIW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
	localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [VAL_W:0]  SUM_LIMIT  = (VAL_W + 1)'(MAX_SUM);
	localparam logic [CNTW-1:0] COIN_LIMIT = CNTW'(MAX_COINS);
	localparam logic [CW-1:0]   NO_WAY     = '1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_COIN  = 7'b0000100,
		ST_ADDR  = 7'b0001000,
		ST_CMP   = 7'b0010000,
		ST_WRITE = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [CNTW-1:0]      count_q;
	logic [CNTW-1:0]      j_q;
	logic [SW-1:0]        s_q;
	logic [SW-1:0]        target_q;
	logic [CW-1:0]        best_q;
	logic [STATUS_W-1:0]  pend_status_q;
	logic [COUNT_W-1:0]   pend_count_q;
	logic                 m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [CMD_W-1:0]     cmd;
	logic [VAL_W-1:0]     coin_in;
	logic [VAL_W-1:0]     target_in;
	logic                 accept;
	logic                 out_free;

	logic                 coin_we;
	logic [VAL_W-1:0]     coin_rdata;
	logic                 cost_we;
	logic [SW-1:0]        cost_waddr;
	logic [CW-1:0]        cost_wdata;
	logic [CW-1:0]        cost_rdata;
	logic [SW-1:0]        cost_raddr;
	logic [CW-1:0]        cand;
	relax_flags_t         flags;

	logic [XW-1:0]        best_x;
	logic [COUNT_W-1:0]   best_sat;

	assign cmd       = s_tdata[1:0];
	assign coin_in   = s_tdata[17:2];
	assign target_in = s_tdata[33:18];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Coin list: written at the fill count, read at the coin cursor.
	assign coin_we = accept && (cmd == CMD_APPEND) && (coin_in != '0) &&
	                 (count_q < COIN_LIMIT);

	mccd_ram #(
		.DEPTH (MAX_COINS),
		.AW    (CIW),
		.DW    (VAL_W)
	) u_coin_ram (
		.clk   (clk),
		.we    (coin_we),
		.waddr (count_q[CIW-1:0]),
		.wdata (coin_in),
		.raddr (j_q[CIW-1:0]),
		.rdata (coin_rdata)
	);

	// Cost table: entry zero is seeded at the start of a solve, each later
	// sum is written once its coin sweep is done.
	assign cost_we    = (state_q == ST_START) || (state_q == ST_WRITE);
	assign cost_waddr = (state_q == ST_START) ? '0 : s_q;
	assign cost_wdata = (state_q == ST_START) ? '0 : best_q;

	mccd_ram #(
		.DEPTH (MAX_SUM),
		.AW    (SW),
		.DW    (CW)
	) u_cost_ram (
		.clk   (clk),
		.we    (cost_we),
		.waddr (cost_waddr),
		.wdata (cost_wdata),
		.raddr (cost_raddr),
		.rdata (cost_rdata)
	);

	mccd_relax_unit #(
		.SW (SW),
		.CW (CW)
	) u_relax (
		.coin  (coin_rdata),
		.sum   (s_q),
		.prev  (cost_rdata),
		.best  (best_q),
		.addr  (cost_raddr),
		.cand  (cand),
		.flags (flags)
	);

	// Counts wider than the output field saturate.
	assign best_x   = XW'(best_q);
	assign best_sat = (best_x > XW'(COUNT_MAX)) ? COUNT_MAX : best_x[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			j_q           <= '0;
			s_q           <= '0;
			target_q      <= '0;
			best_q        <= '0;
			pend_status_q <= ST_SOLVED;
			pend_count_q  <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			// A new word is loaded when the register is free or being drained.
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_APPEND: begin
								if (coin_in != '0) begin
									if (count_q < COIN_LIMIT) begin
										count_q <= count_q + CNTW'(1);
									end else begin
										pend_status_q <= ST_FULL;
										pend_count_q  <= '0;
										state_q       <= ST_EMIT;
									end
								end
							end
							CMD_SOLVE: begin
								if ((VAL_W + 1)'(target_in) >= SUM_LIMIT) begin
									pend_status_q <= ST_TOO_LARGE;
									pend_count_q  <= '0;
									state_q       <= ST_EMIT;
								end else begin
									target_q <= target_in[SW-1:0];
									state_q  <= ST_START;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_START: begin
					if (target_q == '0) begin
						pend_status_q <= ST_SOLVED;
						pend_count_q  <= '0;
						state_q       <= ST_EMIT;
					end else begin
						s_q     <= SW'(1);
						j_q     <= '0;
						best_q  <= NO_WAY;
						state_q <= ST_COIN;
					end
				end
				ST_COIN: begin
					// The coin read at j_q is in flight; stop when the list ends.
					if (j_q < count_q) begin
						state_q <= ST_ADDR;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_ADDR: begin
					// The table read at sum minus coin is issued here.
					if (flags.usable) begin
						state_q <= ST_CMP;
					end else begin
						j_q     <= j_q + CNTW'(1);
						state_q <= ST_COIN;
					end
				end
				ST_CMP: begin
					if (flags.improve) begin
						best_q <= cand;
					end
					j_q     <= j_q + CNTW'(1);
					state_q <= ST_COIN;
				end
				ST_WRITE: begin
					if (s_q == target_q) begin
						if (best_q == NO_WAY) begin
							pend_status_q <= ST_UNREACHABLE;
							pend_count_q  <= '0;
						end else begin
							pend_status_q <= ST_SOLVED;
							pend_count_q  <= best_sat;
						end
						state_q <= ST_EMIT;
					end else begin
						s_q     <= s_q + SW'(1);
						j_q     <= '0;
						best_q  <= NO_WAY;
						state_q <= ST_COIN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word register; loaded only when it is free or being drained.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {2'b00, pend_count_q, pend_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### sv/mccd_checker.sv
module mccd_checker import mccd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// No result word is shown while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result word valid during reset");

	// A stalled result word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	// Only a solved status carries a count; on any other status the padding is zero too.
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ST_SOLVED) |-> (m_tdata[15:2] == '0))
		else $error("count or padding set on a non-solved status");

	// An accepted solve keeps the input closed for at least the next cycle.
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[1:0] == CMD_SOLVE) |=> !s_tready)
		else $error("input ready right after a solve was accepted");

endmodule

bind min_coin_change_dp_unit mccd_checker u_mccd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb_min_coin_change_dp_unit.sv
`timescale 1ns / 100ps

// Self-checking bench for min_coin_change_dp_unit.
// Input words (clear, append, solve and the unused command code) go in through the
// s_* stream. A behavioral copy of the coin list and the cost table works out the
// status and coin count that each word should produce, and queues them in order.
// A checker pops that queue for every word taken from the m_* stream and compares
// the fields one by one. The sender idles in random bursts and the receiver stalls
// in random runs. One test holds the receiver off for a long stretch so that
// results back up and the block stops taking input words.
module tb_min_coin_change_dp_unit;
	import mccd_pkg::*;

	localparam int COINS_MAX   = 16;
	localparam int SUM_LIMIT   = 4096;
	localparam int UNREACHED   = 32'h7fffffff;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 16;
	// The slowest legal run holds one solve of 4095 over two coins and at most
	// about 60 solves of up to 300 with a full list, plus stall overhead. Several
	// times that gives the limit.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} change_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [1:0] command, [17:2] coin_value, [33:18] target_sum, [39:34] zero
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [1:0] status, [13:2] coin_count, [15:14] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Behavioral copy of the block's state.
	logic [VAL_W-1:0] coin_list [0:COINS_MAX-1];
	int               coins_held = 0;
	int               fewest_coins [0:SUM_LIMIT-1];

	change_result_t expected_results [$];

	int errors       = 0;
	int cycles       = 0;
	int words_sent   = 0;
	int results_seen = 0;
	int solves_sent  = 0;
	int refusals     = 0;
	int unreachables = 0;

	// Sender burst control, used only by the stimulus process.
	bit tx_gaps_en = 1'b1;
	int burst_left = 0;

	// Receiver stall control. The stimulus bumps hold_ticket to ask for one long
	// hold-off; the receiver counts that stretch down on its own.
	bit rx_stall_en  = 1'b1;
	int hold_ticket  = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int rx_run_left  = 0;

	min_coin_change_dp_unit #(
		.MAX_COINS(COINS_MAX),
		.MAX_SUM  (SUM_LIMIT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one word to the copy of the state and tells whether it yields a
	// result. Solves fill the table from sum 1 up to the target, taking for each
	// sum the usable coin that leaves the fewest coins in total.
	function automatic bit predict_change(input logic [CMD_W-1:0] cmd,
			input logic [VAL_W-1:0] coin, input logic [VAL_W-1:0] target,
			output change_result_t res);
		int best;
		int prev;
		int c;
		res = '0;
		case (cmd)
			CMD_CLEAR: begin
				coins_held = 0;
				return 1'b0;
			end
			CMD_APPEND: begin
				if (coin == '0)
					return 1'b0;
				if (coins_held >= COINS_MAX) begin
					res.status = ST_FULL;
					return 1'b1;
				end
				coin_list[coins_held] = coin;
				coins_held++;
				return 1'b0;
			end
			CMD_SOLVE: begin
				if (int'(target) >= SUM_LIMIT) begin
					res.status = ST_TOO_LARGE;
					return 1'b1;
				end
				fewest_coins[0] = 0;
				for (int s = 1; s <= int'(target); s++) begin
					best = UNREACHED;
					for (int j = 0; j < coins_held; j++) begin
						c = int'(coin_list[j]);
						if (c != 0 && c <= s) begin
							prev = fewest_coins[s - c];
							if (prev != UNREACHED && prev + 1 < best)
								best = prev + 1;
						end
					end
					fewest_coins[s] = best;
				end
				if (fewest_coins[target] == UNREACHED) begin
					res.status = ST_UNREACHABLE;
				end else begin
					res.status = ST_SOLVED;
					res.count  = (fewest_coins[target] > int'(COUNT_MAX)) ?
						COUNT_MAX : COUNT_W'(fewest_coins[target]);
				end
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Offers one word, waits for the handshake, records what it should produce,
	// then maybe idles before the next word.
	task automatic offer_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] coin,
			input logic [VAL_W-1:0] target);
		change_result_t res;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, target, coin, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
		if (cmd == CMD_SOLVE)
			solves_sent++;
		if (predict_change(cmd, coin, target, res)) begin
			expected_results.push_back(res);
			if (res.status == ST_FULL || res.status == ST_TOO_LARGE)
				refusals++;
			if (res.status == ST_UNREACHABLE)
				unreachables++;
		end
		if (tx_gaps_en) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Waits until every queued result came back, then lets words that produce
	// nothing but may still be in flight settle. The last word was already
	// taken, so the input goes idle first.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Receiver: a long hold-off on request, otherwise random ready/stall runs or, with stalls off, steady ready.
	always @(posedge clk) begin
		if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			hold_left   <= LONG_HOLD - 1;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!rx_stall_en) begin
			m_tready <= 1'b1;
		end else if (rx_run_left != 0) begin
			rx_run_left <= rx_run_left - 1;
		end else begin
			rx_run_left <= $urandom_range(0, 6);
			m_tready    <= ($urandom_range(0, 2) != 0);
		end
	end

	// Checker: every word leaving the block must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, status %0d count %0d", $time,
					m_tdata[1:0], m_tdata[13:2]);
			end else begin
				if (m_tdata[1:0] !== expected_results[0].status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, actual %0d", $time,
						expected_results[0].status, m_tdata[1:0]);
				end
				if (m_tdata[13:2] !== expected_results[0].count) begin
					errors++;
					$display("%0t: coin count mismatch: expected %0d, actual %0d",
						$time, expected_results[0].count, m_tdata[13:2]);
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("tb_min_coin_change_dp_unit: errors");
			$finish;
		end
	end

	// Empty list, zero target, refused targets, the unused command, a zero coin,
	// a coin too big for any sum here, and the largest count the table allows.
	task automatic test_edge_cases();
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd5);
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd0);
		offer_word(CMD_APPEND, 16'd0, VAL_W'($urandom));
		offer_word(CMD_UNUSED, VAL_W'($urandom), VAL_W'($urandom));
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd4096);
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'hffff);
		offer_word(CMD_APPEND, 16'hffff, VAL_W'($urandom));
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd9);
		offer_word(CMD_APPEND, 16'd1, VAL_W'($urandom));
		// Only the unit coin fits, so the count lands exactly on the widest value.
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd4095);
		offer_word(CMD_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd3);
		wait_drained();
	endtask

	// Even coins leave odd sums out of reach; then the list is filled to the brim
	// and one more append must be refused while a zero coin stays ignored.
	task automatic test_full_list();
		offer_word(CMD_APPEND, 16'd2, VAL_W'($urandom));
		offer_word(CMD_APPEND, 16'd4, VAL_W'($urandom));
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd7);
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd8);
		for (int i = 0; i < COINS_MAX - 2; i++)
			offer_word(CMD_APPEND, VAL_W'(3 + 2 * i), VAL_W'($urandom));
		offer_word(CMD_APPEND, 16'd1, VAL_W'($urandom));
		offer_word(CMD_APPEND, 16'd0, VAL_W'($urandom));
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd97);
		offer_word(CMD_SOLVE, VAL_W'($urandom), 16'd1);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while solves keep coming without
	// gaps, so results pile up and the input side has to stall.
	task automatic test_output_backpressure();
		tx_gaps_en = 1'b0;
		offer_word(CMD_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
		offer_word(CMD_APPEND, 16'd3, VAL_W'($urandom));
		offer_word(CMD_APPEND, 16'd5, VAL_W'($urandom));
		hold_ticket <= hold_ticket + 1;
		for (int i = 0; i < 8; i++)
			offer_word(CMD_SOLVE, VAL_W'($urandom), VAL_W'($urandom_range(0, 20)));
		tx_gaps_en = 1'b1;
		wait_drained();
	endtask

	function automatic logic [VAL_W-1:0] pick_target();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return VAL_W'($urandom_range(0, 40));
		if (roll < 9)
			return VAL_W'($urandom_range(41, 300));
		return VAL_W'($urandom_range(SUM_LIMIT, 16'hffff));
	endfunction

	function automatic logic [VAL_W-1:0] pick_coin();
		if ($urandom_range(0, 6) == 0)
			return VAL_W'($urandom_range(1, 16'hffff));
		return VAL_W'($urandom_range(1, 50));
	endfunction

	// Mostly whole sequences (clear, a handful of coins, a few solves) with random
	// content; the rest is loose words, including ignored ones and appends that
	// may land on a full list.
	task automatic test_random_sequences();
		int counted;
		int n;
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] coin;
		logic [VAL_W-1:0] target;
		counted = 0;
		while (counted < 50) begin
			tx_gaps_en  = ($urandom_range(0, 3) != 0);
			rx_stall_en <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				offer_word(CMD_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
				n = $urandom_range(1, COINS_MAX);
				for (int i = 0; i < n; i++)
					offer_word(CMD_APPEND, pick_coin(), VAL_W'($urandom));
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					offer_word(CMD_SOLVE, VAL_W'($urandom), pick_target());
				counted += 1 + coins_held + n;
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					cmd    = CMD_W'($urandom_range(0, 3));
					coin   = ($urandom_range(0, 3) == 0) ? '0 : pick_coin();
					target = pick_target();
					offer_word(cmd, coin, target);
					if (cmd != CMD_UNUSED && !(cmd == CMD_APPEND && coin == '0))
						counted++;
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_full_list();
		test_output_backpressure();
		test_random_sequences();
		s_tvalid <= 1'b0;
		wait_drained();
		$display("Covered %0d words: %0d solves, %0d refusals, %0d unreachable sums.",
			words_sent, solves_sent, refusals, unreachables);
		$display("Checked %0d results in %0d cycles, %0d mismatches.",
			results_seen, cycles, errors);
		if (errors == 0)
			$display("tb_min_coin_change_dp_unit: clean");
		else
			$display("tb_min_coin_change_dp_unit: errors");
		$finish;
	end

endmodule
